### rtl/sha256_stream_hasher_assert.svh
// Assertion macros shared by the SHA-256 stream hasher modules.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`ifndef ASSERT_OFF
// Checks that a condition holds at every clock edge out of reset.
`define SHA256_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Checks that a consequent follows a trigger in the next cycle.
`define SHA256_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA256_ASSERT(lbl, cond)
`define SHA256_ASSERT_NEXT(lbl, trig, cons)
`endif
`endif

### rtl/s256_pkg.sv
// Types, constants and round functions of the SHA-256 stream hasher.
package s256_pkg;

    localparam int QDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_t;

    typedef struct packed {
        logic valid;
        in_t  item;
    } q_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } st_t;

    localparam logic [7:0] PadByte  = 8'h80;
    localparam logic [5:0] LenPos   = 6'd56;
    localparam logic [5:0] LastPos  = 6'd63;
    localparam logic [3:0] LenBytes = 4'd8;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big0(input logic [31:0] x);
        big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml0(input logic [31:0] x);
        sml0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml1(input logic [31:0] x);
        sml1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] init_word(input logic [2:0] i);
        case (i)
            3'd0:    init_word = 32'h6a09e667;
            3'd1:    init_word = 32'hbb67ae85;
            3'd2:    init_word = 32'h3c6ef372;
            3'd3:    init_word = 32'ha54ff53a;
            3'd4:    init_word = 32'h510e527f;
            3'd5:    init_word = 32'h9b05688c;
            3'd6:    init_word = 32'h1f83d9ab;
            default: init_word = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] t);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        round_const = k[t];
    endfunction

endpackage

### rtl/s256_front.sv
// Front end: accepts input words, drops idle words and queues the rest.
`include "sha256_stream_hasher_assert.svh"
module s256_front
    import s256_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic msg_valid,
    output logic msg_stall,
    input  in_t  msg,
    output q_t   q,
    input  logic pop
);

    localparam int PtrW = $clog2(QDepth);
    localparam int CntW = $clog2(QDepth + 1);

    in_t             mem_reg [QDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg, count_next;
    logic            push;
    logic            pop_ok;

    assign msg_stall = (count_reg == CntW'(QDepth));
    // Words with neither a byte nor an end marker have no effect at all.
    assign push    = msg_valid && !msg_stall && (msg.byte_present || msg.end_of_message);
    assign pop_ok  = pop && (count_reg != '0);
    assign q.valid = (count_reg != '0);
    assign q.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= msg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `SHA256_ASSERT(a_count_max, count_reg <= CntW'(QDepth))
    `SHA256_ASSERT(a_pop_nonempty, pop |-> count_reg != '0)
    `SHA256_ASSERT_NEXT(a_push_count, push && !pop_ok, count_reg != '0)

endmodule

### rtl/s256_core.sv
// Back end: block assembly, padding, 64-round compression and digest output.
`include "sha256_stream_hasher_assert.svh"
module s256_core
    import s256_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  q_t   q,
    output logic pop,
    output logic dig_valid,
    input  logic dig_stall,
    output out_t dig
);

    st_t          state_reg, state_next;
    logic [511:0] buf_reg, buf_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic [63:0]  len_reg, len_next;
    logic [31:0]  h_reg [8];
    logic [31:0]  h_next [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];
    logic [5:0]   round_reg, round_next;
    logic         padding_reg, padding_next;
    logic         sent80_reg, sent80_next;
    logic [3:0]   len_cnt_reg, len_cnt_next;
    logic [2:0]   idx_reg, idx_next;
    logic         dig_valid_reg, dig_valid_next;
    out_t         dig_reg, dig_next;

    logic         do_push;
    logic [7:0]   push_byte;
    logic         load_out;
    logic [31:0]  t1, t2, new_w;

    assign pop       = (state_reg == ST_IDLE) && q.valid;
    assign load_out  = (state_reg == ST_OUT) && (!dig_valid_reg || !dig_stall);
    assign dig_valid = dig_valid_reg;
    assign dig       = dig_reg;

    // Byte that enters the block buffer this cycle.
    always_comb
    begin
        do_push   = 1'b0;
        push_byte = '0;
        if (state_reg == ST_IDLE)
        begin
            do_push   = q.valid && q.item.byte_present;
            push_byte = q.item.data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            do_push = 1'b1;
            if (!sent80_reg)
            begin
                push_byte = PadByte;
            end
            else if (len_cnt_reg == '0 && fill_reg != LenPos)
            begin
                push_byte = '0;
            end
            else
            begin
                push_byte = len_reg[63:56];
            end
        end
    end

    assign t1 = v_reg[7] + big1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + round_const(round_reg) + buf_reg[511:480];
    assign t2 = big0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign new_w = sml1(buf_reg[63:32]) + buf_reg[223:192] + sml0(buf_reg[479:448])
                 + buf_reg[511:480];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_push && fill_reg == LastPos)
                begin
                    state_next = ST_ROUND;
                end
                else if (q.valid && q.item.end_of_message)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LastPos)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (len_cnt_reg == LenBytes)
                begin
                    state_next = ST_OUT;
                end
                else if (padding_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == LastPos)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                if (load_out && idx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        buf_next       = buf_reg;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        len_next       = len_reg;
        h_next         = h_reg;
        v_next         = v_reg;
        round_next     = round_reg;
        padding_next   = padding_reg;
        sent80_next    = sent80_reg;
        len_cnt_next   = len_cnt_reg;
        idx_next       = idx_reg;
        dig_valid_next = dig_valid_reg;
        dig_next       = dig_reg;

        if (dig_valid_reg && !dig_stall)
        begin
            dig_valid_next = 1'b0;
        end

        if (do_push)
        begin
            buf_next  = {buf_reg[503:0], push_byte};
            fill_next = fill_reg + 1'b1;
            if (fill_reg == LastPos)
            begin
                v_next     = h_reg;
                round_next = '0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q.valid && q.item.end_of_message)
                begin
                    padding_next = 1'b1;
                end
            end
            ST_PAD:
            begin
                if (!sent80_reg)
                begin
                    sent80_next = 1'b1;
                    len_next    = bits_reg + {55'b0, fill_reg, 3'b0};
                end
                else if (len_cnt_reg != '0 || fill_reg == LenPos)
                begin
                    len_next     = {len_reg[55:0], 8'h00};
                    len_cnt_next = len_cnt_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                buf_next   = {buf_reg[479:0], new_w};
                round_next = round_reg + 1'b1;
                v_next[7]  = v_reg[6];
                v_next[6]  = v_reg[5];
                v_next[5]  = v_reg[4];
                v_next[4]  = v_reg[3] + t1;
                v_next[3]  = v_reg[2];
                v_next[2]  = v_reg[1];
                v_next[1]  = v_reg[0];
                v_next[0]  = t1 + t2;
            end
            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                bits_next = bits_reg + 64'd512;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    dig_valid_next       = 1'b1;
                    dig_next.digest_word = h_reg[idx_reg];
                    dig_next.word_index  = idx_reg;
                    dig_next.last_word   = (idx_reg == 3'd7);
                    idx_next             = idx_reg + 1'b1;
                    if (idx_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            h_next[i] = init_word(3'(i));
                        end
                        bits_next    = '0;
                        fill_next    = '0;
                        padding_next = 1'b0;
                        sent80_next  = 1'b0;
                        len_cnt_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        len_reg  <= len_next;
        v_reg    <= v_next;
        dig_reg  <= dig_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            round_reg     <= '0;
            padding_reg   <= 1'b0;
            sent80_reg    <= 1'b0;
            len_cnt_reg   <= '0;
            idx_reg       <= '0;
            dig_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_word(3'(i));
            end
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            round_reg     <= round_next;
            padding_reg   <= padding_next;
            sent80_reg    <= sent80_next;
            len_cnt_reg   <= len_cnt_next;
            idx_reg       <= idx_next;
            dig_valid_reg <= dig_valid_next;
            h_reg         <= h_next;
        end
    end

    `SHA256_ASSERT(a_out_fill, state_reg == ST_OUT |-> fill_reg == '0)
    `SHA256_ASSERT_NEXT(a_round_end, state_reg == ST_ROUND && round_reg == LastPos,
                        state_reg == ST_ADD)
    `SHA256_ASSERT(a_out_hold, dig_valid_reg && dig_reg.word_index != 3'd7 |->
                   state_reg == ST_OUT)

endmodule

### rtl/sha256_stream_hasher.sv
// Top level of the streaming SHA-256 hasher.
//
//   channel  dir  payload                                      handshake
//   msg      in   data_byte, byte_present, end_of_message      msg_valid / msg_stall
//   dig      out  digest_word, word_index, last_word           dig_valid / dig_stall
//
// The back end takes bytes only while idle; the 64th byte of a block starts the rounds
// (ST_ROUND) and the chaining add (ST_ADD), and no new byte is taken until they are done.
// End of message shifts in the padding one byte per cycle (up to 72 bytes) with one
// or two compressions, then the eight digest words leave one per cycle unless stalled.
// Reset is asynchronous and active low; it loads the initial hash values.
// A four-word queue parts the front from the back, so msg_stall rises only when
// the queue is full; the output register holds a word while dig_stall is high.
module sha256_stream_hasher
    import s256_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic msg_valid,
    output logic msg_stall,
    input  in_t  msg,
    output logic dig_valid,
    input  logic dig_stall,
    output out_t dig
);

    // The queue head travels to the back end as one struct; pop frees it.
    q_t   q;
    logic pop;

    s256_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .q         (q),
        .pop       (pop)
    );

    // The back end assembles blocks, pads, compresses and emits each word.
    s256_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (q),
        .pop       (pop),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

endmodule

### tb/testbench.sv
// Self-checking testbench for the streaming SHA-256 hasher.
`timescale 1ns / 1ps

// Holds a software SHA-256 model and the queue of digest words still owed.
class digest_board;
    logic [7:0]  blk [64];
    logic [5:0]  fill;
    logic [63:0] bits;
    logic [31:0] hw [8];
    s256_pkg::out_t owed [$];
    int errors;
    int digests;

    function new();
        errors = 0;
        digests = 0;
        restart();
    endfunction

    function void restart();
        hw = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        fill = 0;
        bits = 0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        end
        for (int t = 16; t < 64; t++)
        begin
            w[t] = w[t-16] + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
        end
        v = hw;
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + s256_pkg::round_const(6'(t)) + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
        begin
            hw[k] = hw[k] + v[k];
        end
    endfunction

    // Notes one accepted word; an end marker pads the message and queues the digest.
    function void note_word(s256_pkg::in_t it);
        logic [63:0] total;
        int pos;
        s256_pkg::out_t o;
        if (it.byte_present)
        begin
            blk[fill] = it.data_byte;
            fill = fill + 1;
            if (fill == 0)
            begin
                compress();
                bits = bits + 512;
            end
        end
        if (!it.end_of_message)
            return;
        total = bits + 64'(fill) * 8;
        pos = fill;
        blk[pos++] = 8'h80;
        if (pos > 56)
        begin
            while (pos < 64) blk[pos++] = 0;
            compress();
            pos = 0;
        end
        while (pos < 56) blk[pos++] = 0;
        for (int k = 0; k < 8; k++)
        begin
            blk[63-k] = total[8*k +: 8];
        end
        compress();
        for (int k = 0; k < 8; k++)
        begin
            o.digest_word = hw[k];
            o.word_index = 3'(k);
            o.last_word = (k == 7);
            owed = {owed, o};
        end
        restart();
    endfunction

    function void check_word(s256_pkg::out_t got);
        s256_pkg::out_t exp;
        if (owed.size() == 0)
        begin
            $error("digest word %h with nothing expected", got.digest_word);
            errors++;
            return;
        end
        exp = owed.pop_front();
        if (got.digest_word !== exp.digest_word)
        begin
            $error("digest_word expected %h got %h", exp.digest_word, got.digest_word);
            errors++;
        end
        if (got.word_index !== exp.word_index)
        begin
            $error("word_index expected %0d got %0d", exp.word_index, got.word_index);
            errors++;
        end
        if (got.last_word !== exp.last_word)
        begin
            $error("last_word expected %0d got %0d", exp.last_word, got.last_word);
            errors++;
        end
        if (got.last_word)
            digests++;
    endfunction
endclass

module testbench;
    import s256_pkg::*;

    localparam int StallLimit = 5000;

    logic clk = 0;
    logic rst_n = 0;
    logic msg_valid = 0;
    logic msg_stall;
    in_t  msg = '0;
    logic dig_valid;
    logic dig_stall = 0;
    out_t dig;

    int src_idle = 0;
    int sink_busy = 0;
    int quiet = 0;
    int sent = 0;
    bit timed_out = 0;
    digest_board board;

    sha256_stream_hasher dut (.*);

    always #5 clk = ~clk;

    // Both sides are sampled at the edge: the word seen here is the one that was
    // presented before the edge, so event order inside the time step does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (msg_valid && !msg_stall)
                board.note_word(msg);
            if (dig_valid && !dig_stall)
                board.check_word(dig);
            if ((msg_valid && !msg_stall) || (dig_valid && !dig_stall))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            dig_stall <= ($urandom_range(99) < sink_busy);
        end
    end

    // The watchdog ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (quiet >= StallLimit && !timed_out)
        begin
            timed_out = 1;
            $display("== FAIL ==");
            $finish;
        end
    end

    // Presents one word and holds it until the block takes it.
    task automatic send_word(logic [7:0] b, logic p, logic e);
        while ($urandom_range(99) < src_idle)
        begin
            msg_valid <= 0;
            @(posedge clk);
        end
        msg_valid <= 1;
        msg <= '{data_byte: b, byte_present: p, end_of_message: e};
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        sent++;
    endtask

    // Sends a message of n random bytes; a bare end marker closes it when asked.
    task automatic send_message(int n, bit bare_end);
        for (int i = 0; i < n; i++)
        begin
            send_word(8'($urandom), 1, !bare_end && (i == n - 1));
        end
        if (bare_end || n == 0)
            send_word(8'($urandom), 0, 1);
    endtask

    task automatic drain();
        msg_valid <= 0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        int lens [4];
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty message, an idle word, extreme bytes and a short message.
        send_word(8'h00, 0, 1);
        send_word(8'hff, 0, 0);
        send_word(8'h00, 1, 0);
        send_word(8'hff, 1, 1);
        send_word(8'h61, 1, 0);
        send_word(8'h62, 1, 0);
        send_word(8'h63, 1, 1);
        drain();

        // Each phase sends one message at a padding boundary and four more random messages
        // or idle words, under its own idle pattern.
        lens = '{55, 56, 64, 63};
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle = (ph == 1 || ph == 3) ? (ph == 3 ? 37 : 57) : 0;
            sink_busy = (ph == 2 || ph == 3) ? (ph == 3 ? 37 : 57) : 0;
            send_message(lens[ph], ph[0]);
            for (int m = 0; m < 4; m++)
            begin
                case ($urandom_range(9))
                    0: send_word(8'($urandom), 0, 0);
                    default: send_message($urandom_range(12), $urandom_range(1));
                endcase
            end
            drain();
        end
        src_idle = 0;
        sink_busy = 0;
        drain();

        $display("Sent %0d words; checked %0d digests under four idle patterns.",
                 sent, board.digests);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
